// File: hw/rtl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and constants of the 4-bit character LCD write
// sequencer: transaction payloads, controller/datapath command bundle,
// mode, register and phase codes, tick reset values.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   // Width of every tick count (configuration registers and phase hold).
   localparam int HOLD_BITS = 20;

   localparam int CSR_IDX_BITS = 3;

   // Reset values of the tick registers.
   localparam logic [HOLD_BITS-1:0] SETUP_TICKS_RST      = HOLD_BITS'(320);
   localparam logic [HOLD_BITS-1:0] PULSE_TICKS_RST      = HOLD_BITS'(2200);
   localparam logic [HOLD_BITS-1:0] GAP_TICKS_RST        = HOLD_BITS'(90);
   localparam logic [HOLD_BITS-1:0] EXEC_TICKS_RST       = HOLD_BITS'(92000);
   localparam logic [HOLD_BITS-1:0] POWERUP_TICKS_RST    = HOLD_BITS'(120000);
   localparam logic [HOLD_BITS-1:0] INIT_PULSE_TICKS_RST = HOLD_BITS'(120);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SETUP_TICKS      = 3'd0,
      CSR_PULSE_TICKS      = 3'd1,
      CSR_GAP_TICKS        = 3'd2,
      CSR_EXEC_TICKS       = 3'd3,
      CSR_POWERUP_TICKS    = 3'd4,
      CSR_INIT_PULSE_TICKS = 3'd5
   } csr_idx_type;

   // Request modes.
   typedef enum logic [2:0] {
      MODE_CMD   = 3'd0,
      MODE_DATA  = 3'd1,
      MODE_GOTO  = 3'd2,
      MODE_INIT  = 3'd3,
      MODE_GLYPH = 3'd4
   } mode_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_POWERUP = 2'd1,
      ST_BYTE    = 2'd2,
      ST_PULSE   = 2'd3
   } state_type;

   // Kind of phase the datapath builds.
   typedef enum logic [1:0] {
      KIND_POWERUP = 2'd0,
      KIND_BYTE    = 2'd1,
      KIND_PULSE   = 2'd2
   } kind_type;

   // Phase positions inside one byte write.
   localparam logic [2:0] PH_HI_SETUP = 3'd0;
   localparam logic [2:0] PH_HI_PULSE = 3'd1;
   localparam logic [2:0] PH_HI_GAP   = 3'd2;
   localparam logic [2:0] PH_LO_SETUP = 3'd3;
   localparam logic [2:0] PH_LO_PULSE = 3'd4;
   localparam logic [2:0] PH_LO_EXEC  = 3'd5;

   // Byte positions with a meaning of their own.
   localparam logic [3:0] BYTE_FIRST      = 4'd0;
   localparam logic [3:0] BYTE_AFTER_WAKE = 4'd1;
   localparam logic [3:0] BYTE_LAST_ONE   = 4'd0;
   localparam logic [3:0] BYTE_LAST_INIT  = 4'd4;
   localparam logic [3:0] BYTE_LAST_GLYPH = 4'd9;

   // Display command bytes.
   localparam logic [7:0] LCD_WAKE      = 8'h03;
   localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
   localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY     = 8'h06;
   localparam logic [7:0] LCD_CLEAR     = 8'h01;
   localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
   localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
   localparam logic [3:0] LCD_WAKE_NIB  = 4'h3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  byte_value;
      logic [5:0]  column;
      logic [1:0]  row;
      logic [2:0]  glyph_slot;
      logic [63:0] glyph_rows;
   } req_type;

   typedef struct packed {
      logic                 reg_select;
      logic                 enable;
      logic [3:0]           data_nibble;
      logic [HOLD_BITS-1:0] hold_ticks;
      logic                 last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load;
      logic       emit;
      kind_type   kind;
      logic [2:0] phase;
      logic [3:0] byte_idx;
      logic       last;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;
   } sts_type;

   // Index of the final byte of a request.
   function automatic logic [3:0] last_byte(input mode_type mode);
      logic [3:0] idx;
      case (mode)
         MODE_INIT:  idx = BYTE_LAST_INIT;
         MODE_GLYPH: idx = BYTE_LAST_GLYPH;
         default:    idx = BYTE_LAST_ONE;
      endcase
      return idx;
   endfunction

   // Init bytes: wake byte first, then the four setup commands.
   function automatic logic [7:0] init_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = LCD_WAKE;
         4'd1:    b = LCD_FUNC_SET;
         4'd2:    b = LCD_DISP_ON;
         4'd3:    b = LCD_ENTRY;
         default: b = LCD_CLEAR;
      endcase
      return b;
   endfunction

endpackage

// File: hw/rtl/lcdseq_ctrl.sv
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencing state machine: walks power-up wait, byte phases and bare init
// pulses, and issues one phase command per cycle while the output is free.
// ----------------------------------------------------------------------------
module lcdseq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_mode,
   output logic                 req_stall,
   input  lcdseq_pkg::sts_type  sts,
   output lcdseq_pkg::cmd_type  cmd,
   output lcdseq_pkg::state_type state
);

   lcdseq_pkg::state_type state_ff, state_in;
   lcdseq_pkg::mode_type  mode_ff, mode_in;
   logic [2:0]            phase_ff, phase_in;
   logic [3:0]            byte_ff, byte_in;
   logic                  accept;

   assign req_stall = reset || (state_ff != lcdseq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign state     = state_ff;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      byte_in  = byte_ff;
      case (state_ff)
         lcdseq_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in  = lcdseq_pkg::mode_type'(req_mode);
               phase_in = lcdseq_pkg::PH_HI_SETUP;
               byte_in  = lcdseq_pkg::BYTE_FIRST;
               case (lcdseq_pkg::mode_type'(req_mode))
                  lcdseq_pkg::MODE_CMD, lcdseq_pkg::MODE_DATA,
                  lcdseq_pkg::MODE_GOTO, lcdseq_pkg::MODE_GLYPH:
                     state_in = lcdseq_pkg::ST_BYTE;
                  lcdseq_pkg::MODE_INIT:
                     state_in = lcdseq_pkg::ST_POWERUP;
                  default:
                     state_in = lcdseq_pkg::ST_IDLE;  // unused mode: dropped
               endcase
            end
         end
         lcdseq_pkg::ST_POWERUP: begin
            if (sts.out_free) begin
               state_in = lcdseq_pkg::ST_BYTE;
            end
         end
         lcdseq_pkg::ST_BYTE: begin
            if (sts.out_free) begin
               if (phase_ff == lcdseq_pkg::PH_LO_EXEC) begin
                  phase_in = lcdseq_pkg::PH_HI_SETUP;
                  if (byte_ff == lcdseq_pkg::last_byte(mode_ff)) begin
                     state_in = lcdseq_pkg::ST_IDLE;
                  end else if (mode_ff == lcdseq_pkg::MODE_INIT &&
                               byte_ff == lcdseq_pkg::BYTE_FIRST) begin
                     state_in = lcdseq_pkg::ST_PULSE;
                  end else begin
                     byte_in = byte_ff + 4'd1;
                  end
               end else begin
                  phase_in = phase_ff + 3'd1;
               end
            end
         end
         lcdseq_pkg::ST_PULSE: begin
            if (sts.out_free) begin
               if (phase_ff == lcdseq_pkg::PH_LO_EXEC) begin
                  phase_in = lcdseq_pkg::PH_HI_SETUP;
                  byte_in  = lcdseq_pkg::BYTE_AFTER_WAKE;
                  state_in = lcdseq_pkg::ST_BYTE;
               end else begin
                  phase_in = phase_ff + 3'd1;
               end
            end
         end
         default: state_in = lcdseq_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.phase    = phase_ff;
      cmd.byte_idx = byte_ff;
      case (state_ff)
         lcdseq_pkg::ST_POWERUP: begin
            cmd.emit = sts.out_free;
            cmd.kind = lcdseq_pkg::KIND_POWERUP;
         end
         lcdseq_pkg::ST_BYTE: begin
            cmd.emit = sts.out_free;
            cmd.kind = lcdseq_pkg::KIND_BYTE;
            cmd.last = (phase_ff == lcdseq_pkg::PH_LO_EXEC) &&
                       (byte_ff == lcdseq_pkg::last_byte(mode_ff));
         end
         lcdseq_pkg::ST_PULSE: begin
            cmd.emit = sts.out_free;
            cmd.kind = lcdseq_pkg::KIND_PULSE;
         end
         default: cmd.kind = lcdseq_pkg::KIND_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdseq_pkg::ST_IDLE;
         mode_ff  <= lcdseq_pkg::MODE_CMD;
         phase_ff <= lcdseq_pkg::PH_HI_SETUP;
         byte_ff  <= lcdseq_pkg::BYTE_FIRST;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         byte_ff  <= byte_in;
      end
   end

endmodule

// File: hw/rtl/lcdseq_dpath.sv
// ----------------------------------------------------------------------------
// lcdseq_dpath
// Request and tick registers, phase builder and the registered result
// stage. Byte, nibble, enable level and hold are picked per phase command.
// ----------------------------------------------------------------------------
module lcdseq_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lcdseq_pkg::req_type                  req_payload,
   input  logic                                 csr_wr_en,
   input  logic [lcdseq_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lcdseq_pkg::HOLD_BITS-1:0]     csr_wdata,
   input  lcdseq_pkg::cmd_type                  cmd,
   output lcdseq_pkg::sts_type                  sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lcdseq_pkg::rsp_type                  rsp_payload
);

   localparam int HB = lcdseq_pkg::HOLD_BITS;

   lcdseq_pkg::req_type req_ff, req_in;
   logic [HB-1:0] setup_ff, setup_in;
   logic [HB-1:0] pulse_ff, pulse_in;
   logic [HB-1:0] gap_ff, gap_in;
   logic [HB-1:0] exec_ff, exec_in;
   logic [HB-1:0] powerup_ff, powerup_in;
   logic [HB-1:0] ipulse_ff, ipulse_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lcdseq_pkg::rsp_type  rsp_ff, rsp_in, phase_rsp;
   logic [7:0]           cur_byte;
   logic                 cur_rs;
   logic [2:0]           row_sel;
   logic [7:0]           goto_cmd;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   assign req_in = cmd.load ? req_payload : req_ff;

   // tick registers
   always_comb begin
      setup_in   = setup_ff;
      pulse_in   = pulse_ff;
      gap_in     = gap_ff;
      exec_in    = exec_ff;
      powerup_in = powerup_ff;
      ipulse_in  = ipulse_ff;
      if (csr_wr_en) begin
         case (lcdseq_pkg::csr_idx_type'(csr_index))
            lcdseq_pkg::CSR_SETUP_TICKS:      setup_in   = csr_wdata;
            lcdseq_pkg::CSR_PULSE_TICKS:      pulse_in   = csr_wdata;
            lcdseq_pkg::CSR_GAP_TICKS:        gap_in     = csr_wdata;
            lcdseq_pkg::CSR_EXEC_TICKS:       exec_in    = csr_wdata;
            lcdseq_pkg::CSR_POWERUP_TICKS:    powerup_in = csr_wdata;
            lcdseq_pkg::CSR_INIT_PULSE_TICKS: ipulse_in  = csr_wdata;
            default: ;  // unmapped index
         endcase
      end
   end

   // DDRAM address: 0x80 + (row-1)*0x40 + column-1, mod 256
   assign goto_cmd = lcdseq_pkg::LCD_SET_DDRAM + {2'(req_ff.row - 2'd1), 6'd0}
                     + {2'd0, req_ff.column} - 8'd1;
   assign row_sel  = 3'(cmd.byte_idx - 4'd1);

   // byte and register select for the current byte position
   always_comb begin
      cur_byte = req_ff.byte_value;
      cur_rs   = 1'b0;
      case (lcdseq_pkg::mode_type'(req_ff.mode))
         lcdseq_pkg::MODE_DATA: cur_rs = 1'b1;
         lcdseq_pkg::MODE_GOTO: cur_byte = goto_cmd;
         lcdseq_pkg::MODE_INIT: cur_byte = lcdseq_pkg::init_byte(cmd.byte_idx);
         lcdseq_pkg::MODE_GLYPH: begin
            if (cmd.byte_idx == lcdseq_pkg::BYTE_FIRST) begin
               cur_byte = lcdseq_pkg::LCD_SET_CGRAM | {2'd0, req_ff.glyph_slot, 3'd0};
            end else if (cmd.byte_idx == lcdseq_pkg::BYTE_LAST_GLYPH) begin
               cur_byte = lcdseq_pkg::LCD_SET_DDRAM;
            end else begin
               cur_byte = req_ff.glyph_rows[8*row_sel +: 8];
               cur_rs   = 1'b1;
            end
         end
         default: ;  // command byte as given
      endcase
   end

   // phase fields
   always_comb begin
      phase_rsp      = '0;
      phase_rsp.last = cmd.last;
      case (cmd.kind)
         lcdseq_pkg::KIND_POWERUP: phase_rsp.hold_ticks = powerup_ff;
         lcdseq_pkg::KIND_PULSE: begin
            // even positions are enable high, odd enable low
            phase_rsp.enable      = ~cmd.phase[0];
            phase_rsp.data_nibble = lcdseq_pkg::LCD_WAKE_NIB;
            phase_rsp.hold_ticks  = ipulse_ff;
         end
         default: begin
            phase_rsp.reg_select  = cur_rs;
            phase_rsp.data_nibble = (cmd.phase < lcdseq_pkg::PH_LO_SETUP) ?
                                    cur_byte[7:4] : cur_byte[3:0];
            case (cmd.phase)
               lcdseq_pkg::PH_HI_SETUP: phase_rsp.hold_ticks = setup_ff;
               lcdseq_pkg::PH_HI_PULSE: begin
                  phase_rsp.enable     = 1'b1;
                  phase_rsp.hold_ticks = pulse_ff;
               end
               lcdseq_pkg::PH_HI_GAP:   phase_rsp.hold_ticks = gap_ff;
               lcdseq_pkg::PH_LO_SETUP: phase_rsp.hold_ticks = setup_ff;
               lcdseq_pkg::PH_LO_PULSE: begin
                  phase_rsp.enable     = 1'b1;
                  phase_rsp.hold_ticks = pulse_ff;
               end
               default:                 phase_rsp.hold_ticks = exec_ff;
            endcase
         end
      endcase
   end

   // result stage
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_in       = phase_rsp;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         setup_ff     <= lcdseq_pkg::SETUP_TICKS_RST;
         pulse_ff     <= lcdseq_pkg::PULSE_TICKS_RST;
         gap_ff       <= lcdseq_pkg::GAP_TICKS_RST;
         exec_ff      <= lcdseq_pkg::EXEC_TICKS_RST;
         powerup_ff   <= lcdseq_pkg::POWERUP_TICKS_RST;
         ipulse_ff    <= lcdseq_pkg::INIT_PULSE_TICKS_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         setup_ff     <= setup_in;
         pulse_ff     <= pulse_in;
         gap_ff       <= gap_in;
         exec_ff      <= exec_in;
         powerup_ff   <= powerup_in;
         ipulse_ff    <= ipulse_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: hw/rtl/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns LCD requests (command, data, goto, init, glyph definition) into
// timed 4-bit bus phases, one result transaction per phase.
// ----------------------------------------------------------------------------
//
//  channel  | ports                           | direction | flow
//  ---------+---------------------------------+-----------+------------------
//  request  | req_valid, req_stall, req_payload | in      | valid / stall
//  result   | rsp_valid, rsp_stall, rsp_payload | out     | valid / stall
//  csr      | csr_wr_en, csr_index, csr_wdata | in        | write only
//
//  Phases: a request makes N phases (N = 6 for a byte, 37 for init, 60 for
//  a glyph), and rsp_stall holds the sequence while the result register is
//  full; an unused mode is taken and yields nothing. The phase counter of
//  the controller emits at most one phase per cycle into the result register.
//  A new request is taken once the final phase sits in the result register.
//  Reset is synchronous and active high; req_stall is held high during it,
//  and the tick registers return to their default values.
//
module char_lcd_nibble_write_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request transactions
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lcdseq_pkg::req_type                  req_payload,
   // result transactions, one per bus phase
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lcdseq_pkg::rsp_type                  rsp_payload,
   // tick register writes
   input  logic                                 csr_wr_en,
   input  logic [lcdseq_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lcdseq_pkg::HOLD_BITS-1:0]     csr_wdata
);

   lcdseq_pkg::cmd_type   cmd;     // phase command from controller
   lcdseq_pkg::sts_type   sts;     // output stage status back
   lcdseq_pkg::state_type state;

   // Controller: owns the request handshake and the phase/byte counters.
   lcdseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   // Datapath: request capture, tick registers, phase build, result stage.
   lcdseq_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A phase is only issued when the result register can take it.
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("phase issued while result register blocked");

   // New requests are only taken when no non-final phase is pending.
   a_idle_only_after_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (!rsp_valid || rsp_payload.last))
      else $error("request taken with phases of previous one pending");

   // Phase counter never leaves the six positions of a byte.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      cmd.phase <= lcdseq_pkg::PH_LO_EXEC)
      else $error("phase counter out of range");

   // The final phase goes out only on the way back to idle.
   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state == lcdseq_pkg::ST_IDLE))
      else $error("final phase issued without returning to idle");

endmodule

// File: dv/char_lcd_nibble_write_sequencer_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_tb
// Self-checking bench for the 4-bit LCD write sequencer. Requests go in on
// the valid/stall channel. A predictor expands every accepted request into
// the bus phases it should produce. Each result transaction is checked field
// by field against the oldest expected phase. A short table of corner cases
// runs first, then random traffic under several tick register settings.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD        = 4;
   localparam int RESET_CYCLES      = 5;
   localparam int DRAIN_CYCLES      = 8;     // an unused mode is still accepted and dropped
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int NUM_SETTINGS      = 5;
   localparam int ITEMS_PER_SETTING = 45;
   localparam int NUM_TICK_REGS     = lcdseq_pkg::CSR_INIT_PULSE_TICKS + 1;
   localparam int HB                = lcdseq_pkg::HOLD_BITS;
   localparam int IB                = lcdseq_pkg::CSR_IDX_BITS;

   localparam logic [HB-1:0] TICKS_MAX = '1;
   localparam logic [7:0] ROW_STRIDE = 8'h40;   // DDRAM offset of one display line

   // mode codes the block does not decode
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;

   typedef struct packed {
      lcdseq_pkg::req_type req;
      logic                head_known;   // first phase typed in below
      lcdseq_pkg::rsp_type head;
   } dir_row_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   lcdseq_pkg::req_type  req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   lcdseq_pkg::rsp_type  rsp_payload;
   logic                 csr_wr_en   = 1'b0;
   logic [IB-1:0]        csr_index   = '0;
   logic [HB-1:0]        csr_wdata   = '0;

   logic [HB-1:0] tick_regs [NUM_TICK_REGS];  // predictor copy of the CSRs
   lcdseq_pkg::rsp_type phase_q [$];     // expected bus phases, oldest first
   lcdseq_pkg::rsp_type burst_q [$];     // phases of the request being expanded
   dir_row_type dir_tab [$];
   int          errors       = 0;
   int          stuck_cycles = 0;
   bit          quiet        = 1'b0;   // no idling on either side

   always #(CLK_PERIOD / 2) clock = ~clock;

   char_lcd_nibble_write_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic lcdseq_pkg::rsp_type mk_phase(logic rs, logic en,
                                                    logic [3:0] nib,
                                                    logic [HB-1:0] hold);
      lcdseq_pkg::rsp_type ph;
      ph.reg_select  = rs;
      ph.enable      = en;
      ph.data_nibble = nib;
      ph.hold_ticks  = hold;
      ph.last        = 1'b0;
      return ph;
   endfunction

   // One byte: high nibble then low nibble, each setup / enable high / enable low.
   function automatic void add_byte(logic rs, logic [7:0] b);
      burst_q.push_back(mk_phase(rs, 1'b0, b[7:4],
                                 tick_regs[lcdseq_pkg::CSR_SETUP_TICKS]));
      burst_q.push_back(mk_phase(rs, 1'b1, b[7:4],
                                 tick_regs[lcdseq_pkg::CSR_PULSE_TICKS]));
      burst_q.push_back(mk_phase(rs, 1'b0, b[7:4],
                                 tick_regs[lcdseq_pkg::CSR_GAP_TICKS]));
      burst_q.push_back(mk_phase(rs, 1'b0, b[3:0],
                                 tick_regs[lcdseq_pkg::CSR_SETUP_TICKS]));
      burst_q.push_back(mk_phase(rs, 1'b1, b[3:0],
                                 tick_regs[lcdseq_pkg::CSR_PULSE_TICKS]));
      burst_q.push_back(mk_phase(rs, 1'b0, b[3:0],
                                 tick_regs[lcdseq_pkg::CSR_EXEC_TICKS]));
   endfunction

   // Expands one request into burst_q; unused modes leave it empty.
   function automatic void expand_request(lcdseq_pkg::req_type r);
      logic [7:0]          ddram;
      lcdseq_pkg::rsp_type tail;
      burst_q.delete();
      // 8-bit arithmetic wraps out-of-range rows and columns on purpose
      ddram = lcdseq_pkg::LCD_SET_DDRAM + {r.row, 6'd0} - ROW_STRIDE
              + {2'b00, r.column} - 8'd1;
      case (r.mode)
         lcdseq_pkg::MODE_CMD:  add_byte(1'b0, r.byte_value);
         lcdseq_pkg::MODE_DATA: add_byte(1'b1, r.byte_value);
         lcdseq_pkg::MODE_GOTO: add_byte(1'b0, ddram);
         lcdseq_pkg::MODE_INIT: begin
            burst_q.push_back(mk_phase(1'b0, 1'b0, 4'h0,
                                       tick_regs[lcdseq_pkg::CSR_POWERUP_TICKS]));
            add_byte(1'b0, lcdseq_pkg::LCD_WAKE);
            repeat (3) begin
               burst_q.push_back(mk_phase(1'b0, 1'b1, lcdseq_pkg::LCD_WAKE_NIB,
                                          tick_regs[lcdseq_pkg::CSR_INIT_PULSE_TICKS]));
               burst_q.push_back(mk_phase(1'b0, 1'b0, lcdseq_pkg::LCD_WAKE_NIB,
                                          tick_regs[lcdseq_pkg::CSR_INIT_PULSE_TICKS]));
            end
            add_byte(1'b0, lcdseq_pkg::LCD_FUNC_SET);
            add_byte(1'b0, lcdseq_pkg::LCD_DISP_ON);
            add_byte(1'b0, lcdseq_pkg::LCD_ENTRY);
            add_byte(1'b0, lcdseq_pkg::LCD_CLEAR);
         end
         lcdseq_pkg::MODE_GLYPH: begin
            add_byte(1'b0, lcdseq_pkg::LCD_SET_CGRAM | {2'b00, r.glyph_slot, 3'b000});
            for (int i = 0; i < 8; i++)
               add_byte(1'b1, r.glyph_rows[8*i +: 8]);
            add_byte(1'b0, lcdseq_pkg::LCD_SET_DDRAM);
         end
         default: ;
      endcase
      if (burst_q.size() != 0) begin
         tail      = burst_q.pop_back();
         tail.last = 1'b1;
         burst_q.push_back(tail);
      end
   endfunction

   function automatic lcdseq_pkg::req_type mk_req(logic [2:0] mode, logic [7:0] b,
                                                  logic [5:0] col, logic [1:0] row,
                                                  logic [2:0] slot,
                                                  logic [63:0] rows);
      lcdseq_pkg::req_type r;
      r.mode       = mode;
      r.byte_value = b;
      r.column     = col;
      r.row        = row;
      r.glyph_slot = slot;
      r.glyph_rows = rows;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Offers one request transaction; once taken, queues its expected phases.
   task automatic send_req(lcdseq_pkg::req_type r, logic head_known = 1'b0,
                           lcdseq_pkg::rsp_type head = '0);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      expand_request(r);
      if (head_known && burst_q.size() != 0)
         burst_q[0] = head;
      foreach (burst_q[i])
         phase_q.push_back(burst_q[i]);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Sender holds off until every expected phase is out, plus the block latency.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (phase_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes every CSR index, spare ones included; spare writes must not land.
   task automatic load_ticks(input logic [HB-1:0] vals [NUM_TICK_REGS]);
      for (int i = 0; i < (1 << IB); i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= IB'(i);
         csr_wdata <= (i < NUM_TICK_REGS) ? vals[i] : HB'($urandom);
         @(posedge clock);
         if (i < NUM_TICK_REGS)
            tick_regs[i] = vals[i];
      end
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [HB-1:0]       setting [NUM_TICK_REGS];
      lcdseq_pkg::req_type r;
      int unsigned         pick;
      int                  sent;

      tick_regs = '{lcdseq_pkg::SETUP_TICKS_RST, lcdseq_pkg::PULSE_TICKS_RST,
                    lcdseq_pkg::GAP_TICKS_RST, lcdseq_pkg::EXEC_TICKS_RST,
                    lcdseq_pkg::POWERUP_TICKS_RST, lcdseq_pkg::INIT_PULSE_TICKS_RST};

      // corner cases at reset tick values; heads typed where obvious
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_CMD, 8'h00, 6'd0, 2'd0, 3'd0, '0),
         1'b1, mk_phase(1'b0, 1'b0, 4'h0, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_CMD, 8'hFF, '1, '1, '1, '1),
         1'b1, mk_phase(1'b0, 1'b0, 4'hF, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_DATA, 8'h00, '1, '1, '1, '1),
         1'b1, mk_phase(1'b1, 1'b0, 4'h0, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_DATA, 8'hFF, 6'd0, 2'd0, 3'd0, '0),
         1'b1, mk_phase(1'b1, 1'b0, 4'hF, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_DATA, 8'h5A, 6'd3, 2'd1, 3'd2, '0), 1'b0, '0});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_CMD, lcdseq_pkg::LCD_CLEAR, 6'd1, 2'd1, 3'd0, '0),
         1'b0, '0});
      // goto: home, far corner of line two, then out-of-range coordinates
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GOTO, 8'hFF, 6'd1, 2'd1, 3'd0, '0),
         1'b1, mk_phase(1'b0, 1'b0, 4'h8, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GOTO, 8'h00, 6'd40, 2'd2, 3'd7, '1),
         1'b1, mk_phase(1'b0, 1'b0, 4'hE, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GOTO, 8'h00, 6'd0, 2'd0, 3'd0, '0), 1'b0, '0});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GOTO, 8'hFF, '1, '1, '1, '1), 1'b0, '0});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GOTO, 8'h00, 6'd41, 2'd2, 3'd0, '0), 1'b0, '0});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_INIT, 8'hFF, '1, '1, '1, '1),
         1'b1, mk_phase(1'b0, 1'b0, 4'h0, lcdseq_pkg::POWERUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GLYPH, 8'hFF, '1, '1, 3'd0, '0),
         1'b1, mk_phase(1'b0, 1'b0, 4'h4, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GLYPH, 8'h00, 6'd0, 2'd0, 3'd7, '1),
         1'b1, mk_phase(1'b0, 1'b0, 4'h7, lcdseq_pkg::SETUP_TICKS_RST)});
      dir_tab.push_back(dir_row_type'{
         mk_req(lcdseq_pkg::MODE_GLYPH, 8'h00, 6'd0, 2'd0, 3'd5,
                64'h0123_4567_89AB_CDEF), 1'b0, '0});
      // unused modes must produce nothing
      dir_tab.push_back(dir_row_type'{
         mk_req(MODE_SPARE_A, 8'h00, 6'd0, 2'd0, 3'd0, '0), 1'b0, '0});
      dir_tab.push_back(dir_row_type'{
         mk_req(MODE_SPARE_B, 8'h3C, 6'd1, 2'd1, 3'd4, '0), 1'b0, '0});
      dir_tab.push_back(dir_row_type'{
         mk_req(MODE_SPARE_C, '1, '1, '1, '1, '1), 1'b0, '0});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_req(dir_tab[i].req, dir_tab[i].head_known, dir_tab[i].head);

      // random traffic: max ticks, min ticks, zero ticks, then random values
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_drained();
         case (s)
            0:       setting = '{default: TICKS_MAX};
            1:       setting = '{default: HB'(1)};
            2:       setting = '{default: '0};
            default: foreach (setting[i])
                        setting[i] = HB'($urandom_range(1, TICKS_MAX));
         endcase
         load_ticks(setting);
         quiet = (s == NUM_SETTINGS - 1);
         sent  = 0;
         while (sent < ITEMS_PER_SETTING) begin
            r.byte_value = 8'($urandom);
            r.column     = 6'($urandom);
            r.row        = 2'($urandom);
            r.glyph_slot = 3'($urandom);
            r.glyph_rows = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 25)
               r.mode = lcdseq_pkg::MODE_CMD;
            else if (pick < 50)
               r.mode = lcdseq_pkg::MODE_DATA;
            else if (pick < 72) begin
               r.mode = lcdseq_pkg::MODE_GOTO;
               // mostly on-screen positions, the rest anywhere the fields reach
               if ($urandom_range(0, 3) != 0) begin
                  r.row    = 2'($urandom_range(1, 2));
                  r.column = 6'($urandom_range(1, 40));
               end
            end else if (pick < 80)
               r.mode = lcdseq_pkg::MODE_INIT;
            else if (pick < 92)
               r.mode = lcdseq_pkg::MODE_GLYPH;
            else
               r.mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
            send_req(r);
            if (r.mode <= lcdseq_pkg::MODE_GLYPH) begin
               sent++;
               // one full drain in the middle of traffic
               if (s == 1 && sent == ITEMS_PER_SETTING / 2)
                  wait_drained();
            end
         end
      end

      wait_drained();
      if (errors == 0)
         $display("char_lcd_nibble_write_sequencer_tb passed");
      else
         $display("char_lcd_nibble_write_sequencer_tb failed");
      $finish;
   end

   // Result-side backpressure in random bursts, none in the final stretch.
   initial begin : rsp_backpressure
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker and watchdog
   // ---------------------------------------------------------------------
   function automatic void report_mismatch(string field, logic [31:0] want_v,
                                           logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
   endfunction

   always @(posedge clock) begin : phase_check
      lcdseq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (phase_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected bus phase, expected none, actual %h",
                     $time, rsp_payload);
         end else begin
            want = phase_q.pop_front();
            if (rsp_payload.reg_select !== want.reg_select)
               report_mismatch("reg_select", 32'(want.reg_select),
                               32'(rsp_payload.reg_select));
            if (rsp_payload.enable !== want.enable)
               report_mismatch("enable", 32'(want.enable), 32'(rsp_payload.enable));
            if (rsp_payload.data_nibble !== want.data_nibble)
               report_mismatch("data_nibble", 32'(want.data_nibble),
                               32'(rsp_payload.data_nibble));
            if (rsp_payload.hold_ticks !== want.hold_ticks)
               report_mismatch("hold_ticks", 32'(want.hold_ticks),
                               32'(rsp_payload.hold_ticks));
            if (rsp_payload.last !== want.last)
               report_mismatch("last", 32'(want.last), 32'(rsp_payload.last));
         end
      end
      // any transaction on either channel counts as progress
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d phases outstanding",
                  $time, stuck_cycles, phase_q.size());
         $display("char_lcd_nibble_write_sequencer_tb failed");
         $finish;
      end
   end

endmodule

// File: filelist.f
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_ctrl.sv
hw/rtl/lcdseq_dpath.sv
hw/rtl/char_lcd_nibble_write_sequencer.sv
dv/char_lcd_nibble_write_sequencer_tb.sv
